>>> hw/rtl/lnds_pkg.sv
package lnds_pkg;

    localparam int unsigned VALUE_IN_W = 32;
    localparam int unsigned LENGTH_W   = 7;

    typedef logic signed [VALUE_IN_W-1:0] t_value_in;
    typedef logic [LENGTH_W-1:0]          t_length;

    // Per-cell control driven from the top level.
    typedef struct packed {
        logic accept;
        logic occupied;
        logic at_end;
    } t_cell_ctl;

    // Status that each cell hands back.
    typedef struct packed {
        logic gt;
        logic write;
        logic append;
    } t_cell_sts;

endpackage

>>> hw/rtl/lnds_ifs.sv
interface lnds_in_if;
    logic                    valid;
    logic                    ready;
    lnds_pkg::t_value_in     value;
    logic                    end_of_sequence;

    modport source (output valid, output value, output end_of_sequence, input ready);
    modport sink   (input valid, input value, input end_of_sequence, output ready);
endinterface

interface lnds_out_if;
    logic                    valid;
    logic                    ready;
    lnds_pkg::t_length       length;
    logic                    final_result;
    logic                    overflow;

    modport source (output valid, output length, output final_result, output overflow,
                    input ready);
    modport sink   (input valid, input length, input final_result, input overflow,
                    output ready);
endinterface

>>> hw/rtl/lnds_cell.sv
module lnds_cell #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  lnds_pkg::t_cell_ctl           i_ctl,
    input  logic signed [VALUE_WIDTH-1:0] i_key,
    input  logic                          i_prev_gt,
    output lnds_pkg::t_cell_sts           o_sts
);

    logic signed [VALUE_WIDTH-1:0] r_tail;
    logic                          gt;
    logic                          write;

    always_comb begin
        gt    = i_ctl.occupied && (r_tail > i_key);
        write = i_ctl.accept && !i_prev_gt && (gt || i_ctl.at_end);
        o_sts.gt     = gt;
        o_sts.write  = write;
        o_sts.append = i_ctl.at_end && !i_prev_gt;
    end

    always_ff @(posedge i_clk) begin
        if (write) begin
            r_tail <= i_key;
        end
    end

endmodule

>>> hw/rtl/longest_nondecreasing_subseq_len.sv
// Streaming longest non-decreasing subsequence length.
// Input beats on i_in carry a signed value and an end_of_sequence mark.
// Each input beat yields exactly one output beat on o_out with the current
// length, a copy of the end mark in final_result, and the sticky overflow
// flag of the current sequence.
// The tails live in a row of cells, one tail per cell. Every cell compares
// the incoming value with its own tail in the same cycle and passes the
// result to its right-hand neighbor, so the cell that holds the first
// greater tail, or the first empty cell, takes the value.
// A result is registered and shows on o_out in the cycle after its beat;
// one beat per cycle is sustained: the output register is refilled in the
// cycle it is drained; the input stalls only while a result waits unread.
// Reset clears the tail count, the overflow flag and the output valid.
// After a beat marked end_of_sequence the table starts empty again.
// If the table is full, a value that would extend it is dropped and
// overflow stays high until the end of that sequence.
module longest_nondecreasing_subseq_len #(
    parameter int unsigned TAILS_DEPTH = 64,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lnds_in_if.sink     i_in,
    lnds_out_if.source  o_out
);

    localparam int unsigned CW = $clog2(TAILS_DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_ovf_seen;
    logic          n_ovf_seen;
    logic          r_out_valid;
    logic [CW-1:0] r_length;
    logic          r_final;
    logic          r_ovf;

    logic                          accept;
    logic signed [VALUE_WIDTH-1:0] key;
    logic [TAILS_DEPTH-1:0]        gt_vec;
    logic [TAILS_DEPTH-1:0]        wr_vec;
    logic [TAILS_DEPTH-1:0]        app_vec;
    logic                          any_app;
    logic                          ovf_now;
    logic [CW-1:0]                 new_count;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    generate
        if (VALUE_WIDTH <= lnds_pkg::VALUE_IN_W) begin : g_key_trunc
            assign key = i_in.value[VALUE_WIDTH-1:0];
        end else begin : g_key_ext
            assign key = {{(VALUE_WIDTH - lnds_pkg::VALUE_IN_W){i_in.value[lnds_pkg::VALUE_IN_W-1]}},
                          i_in.value};
        end
    endgenerate

    genvar g;
    generate
        for (g = 0; g < TAILS_DEPTH; g++) begin : g_cell
            lnds_pkg::t_cell_ctl ctl;
            lnds_pkg::t_cell_sts sts;
            logic                prev_gt;

            assign ctl.accept   = accept;
            assign ctl.occupied = CW'(g) < r_count;
            assign ctl.at_end   = CW'(g) == r_count;

            if (g == 0) begin : g_first
                assign prev_gt = 1'b0;
            end else begin : g_rest
                assign prev_gt = gt_vec[g-1];
            end

            lnds_cell #(
                .VALUE_WIDTH(VALUE_WIDTH)
            ) u_cell (
                .i_clk     (i_clk),
                .i_ctl     (ctl),
                .i_key     (key),
                .i_prev_gt (prev_gt),
                .o_sts     (sts)
            );

            assign gt_vec[g]  = sts.gt;
            assign wr_vec[g]  = sts.write;
            assign app_vec[g] = sts.append;
        end
    endgenerate

    always_comb begin
        any_app   = |app_vec;
        ovf_now   = (r_count == CW'(TAILS_DEPTH)) && !gt_vec[TAILS_DEPTH-1];
        new_count = any_app ? r_count + CW'(1) : r_count;
        n_count    = r_count;
        n_ovf_seen = r_ovf_seen;
        if (accept) begin
            if (i_in.end_of_sequence) begin
                n_count    = '0;
                n_ovf_seen = 1'b0;
            end else begin
                n_count    = new_count;
                n_ovf_seen = r_ovf_seen || ovf_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf_seen  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_ovf_seen <= n_ovf_seen;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_length <= new_count;
            r_final  <= i_in.end_of_sequence;
            r_ovf    <= r_ovf_seen || ovf_now;
        end
    end

    generate
        if (CW >= lnds_pkg::LENGTH_W) begin : g_len_trunc
            assign o_out.length = r_length[lnds_pkg::LENGTH_W-1:0];
        end else begin : g_len_ext
            assign o_out.length = {{(lnds_pkg::LENGTH_W - CW){1'b0}}, r_length};
        end
    endgenerate

    assign o_out.valid        = r_out_valid;
    assign o_out.final_result = r_final;
    assign o_out.overflow     = r_ovf;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TAILS_DEPTH))
        else $error("tail count exceeds table depth");

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(wr_vec))
        else $error("more than one cell written by one beat");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf_seen |-> (r_count == CW'(TAILS_DEPTH)))
        else $error("overflow flagged while table not full");

    a_eos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.end_of_sequence) |=> (r_count == '0 && !r_ovf_seen))
        else $error("table not cleared after end of sequence");

    a_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !ovf_now) |-> $onehot(wr_vec))
        else $error("accepted beat wrote no cell without overflow");

endmodule
